// File: design/bsa_pkg.sv
// shared types and codes for the bitmap slot allocator
package bsa_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_GET   = 2'd2;
  localparam logic [1:0] FN_SET   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted;
  } slot_cmd_t;

endpackage

// File: design/bsa_ram.sv
// generic single-write single-read ram with registered read
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/bsa_front.sv
// front end: takes commands, checks them against the bitmap, updates the bitmap
module bsa_front #(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [7:0]        slot_index,
  input  logic [63:0]       slot_value,
  input  logic              full,
  output logic              push,
  output bsa_pkg::slot_cmd_t cmd
);
  import bsa_pkg::*;

  localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0] used_map, used_map_next;
  logic [SLOT_COUNT-1:0] free_vec, low_vec;
  logic [IDX_W-1:0]      grant_idx;
  logic [IDX_W-1:0]      slot_sel;
  logic                  in_range, allocated;

  assign push     = start && !full;
  assign in_range = ({1'b0, slot_index} < 9'(SLOT_COUNT));
  assign slot_sel = slot_index[IDX_W-1:0];
  assign allocated = in_range && used_map[slot_sel];

  always_comb begin
    free_vec  = ~used_map;
    low_vec   = free_vec & (~free_vec + 1'b1);
    grant_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (low_vec[i]) begin
        grant_idx = grant_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.status    = ST_OK;
    cmd.kind      = KIND_NONE;
    used_map_next = used_map;
    unique case (func)
      FN_ALLOC: begin
        if (|free_vec) begin
          cmd.kind      = KIND_WRITE;
          cmd.addr      = ADDR_W'(grant_idx);
          cmd.granted   = ADDR_W'(grant_idx);
          used_map_next = used_map | low_vec;
        end else begin
          cmd.status = ST_FULL;
        end
      end
      default: begin
        if (!in_range) begin
          cmd.status = ST_RANGE;
        end else if (!allocated) begin
          cmd.status = ST_NOT_ALLOC;
        end else begin
          cmd.addr = ADDR_W'(slot_sel);
          unique case (func)
            FN_FREE: begin
              cmd.kind      = KIND_WRITE;
              used_map_next = used_map & ~(SLOT_COUNT'(1) << slot_sel);
            end
            FN_GET: begin
              cmd.kind = KIND_READ;
            end
            default: begin
              cmd.kind  = KIND_WRITE;
              cmd.wdata = slot_value;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (push) begin
      used_map <= used_map_next;
    end
  end

endmodule

// File: design/bsa_queue.sv
// two-entry command queue between front and back
module bsa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bsa_pkg::slot_cmd_t push_cmd,
  input  logic               pop,
  output bsa_pkg::slot_cmd_t head,
  output logic               empty,
  output logic               full
);
  import bsa_pkg::*;

  slot_cmd_t  entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/bsa_back.sv
// back end: applies queued commands to the value store and drives results
module bsa_back #(
  parameter int SLOT_COUNT  = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  bsa_pkg::slot_cmd_t head,
  output logic               pop,
  output logic               done,
  output logic [1:0]         status,
  output logic [5:0]         granted_index,
  output logic [63:0]        read_value
);
  import bsa_pkg::*;

  localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_addr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic                   res_valid, res_read;
  logic [1:0]             res_status;
  logic [ADDR_W-1:0]      res_granted;

  assign pop      = !empty;
  assign ram_we   = pop && (head.kind == KIND_WRITE);
  assign ram_re   = pop && (head.kind == KIND_READ);
  assign ram_addr = head.addr[IDX_W-1:0];

  bsa_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (head.wdata[VALUE_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_read  <= 1'b0;
    end else begin
      res_valid <= pop;
      res_read  <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_status  <= head.status;
      res_granted <= head.granted;
    end
  end

  assign done          = res_valid;
  assign status        = res_status;
  assign granted_index = res_granted;
  assign read_value    = res_read ? 64'(ram_rdata) : 64'd0;

endmodule

// File: design/bitmap_slot_allocator.sv
// top level of the bitmap slot allocator
// done rises once an accepted command has passed the queue entry and then the back end's result register
// throughput: one command per cycle; the value store's single write/read port sets this
// busy rises only when the two-entry queue fills, which steady draining never allows
// reset clears the bitmap, the queue and the result strobe; the value store is not cleared,
// allocate zeroes a slot before it can be read
module bitmap_slot_allocator #(
  parameter int SLOT_COUNT  = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  slot_index,
  input  logic [63:0] slot_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  granted_index,
  output logic [63:0] read_value
);
  import bsa_pkg::*;

  slot_cmd_t front_cmd, head;
  logic      push, pop, empty, full;

  assign busy = full;

  bsa_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .slot_index (slot_index),
    .slot_value (slot_value),
    .full       (full),
    .push       (push),
    .cmd        (front_cmd)
  );

  bsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  bsa_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .read_value    (read_value)
  );

endmodule

// File: design/bsa_checker.sv
// port-level checks for the bitmap slot allocator, bound to the top level
module bsa_assertions (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        done,
  input logic [1:0]  status,
  input logic [5:0]  granted_index,
  input logic [63:0] read_value
);
  import bsa_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction gave no result");

  a_done_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (granted_index == 6'd0 && read_value == 64'd0))
    else $error("failed transaction returned data");

  a_read_from_get: assert property (@(posedge clk) disable iff (rst)
    (done && read_value != 64'd0) |-> $past(func == FN_GET, 2))
    else $error("read value on a non-get transaction");

endmodule

bind bitmap_slot_allocator bsa_assertions u_chk (.*);
